/* hdl/yuv420_planar_to_rgb_top_assert.svh */
// ----------------------------------------------------------------------------
// yuv420_planar_to_rgb_top_assert.svh
// Assertion macros used by the checker of the planar 4:2:0 converter.
// ----------------------------------------------------------------------------
`ifndef YUV420_PLANAR_TO_RGB_TOP_ASSERT_SVH
`define YUV420_PLANAR_TO_RGB_TOP_ASSERT_SVH

// same-cycle implication, gated by reset
`define Y420RGB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("y420rgb: same-cycle check failed");

// next-cycle implication, gated by reset
`define Y420RGB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("y420rgb: next-cycle check failed");

`endif

/* hdl/y420rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y420rgb_pkg
// Types, register indexes and conversion constants of the 4:2:0 converter.
// ----------------------------------------------------------------------------
package y420rgb_pkg;

	localparam int CFG_W = 11;
	localparam int CH_W  = 11;

	typedef logic [CFG_W-1:0]       dim_cfg_t;
	typedef logic signed [CH_W-1:0] chan_t;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam dim_cfg_t DIM_RESET = 11'd64;

	localparam chan_t R_BIAS   = 11'sd179;
	localparam chan_t G_BIAS_U = 11'sd44;
	localparam chan_t G_BIAS_V = 11'sd91;
	localparam chan_t B_BIAS   = 11'sd227;
	localparam chan_t CLIP_MAX = 11'sd255;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIM,
		ST_POS,
		ST_CLASS,
		ST_CHROMA,
		ST_DIV,
		ST_BASE,
		ST_ADDR,
		ST_READ,
		ST_OUT
	} y420rgb_state_t;

	function automatic logic [7:0] clip8(input chan_t v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > CLIP_MAX) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

/* hdl/y420rgb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y420rgb_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module y420rgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hdl/yuv420_planar_to_rgb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_planar_to_rgb_top
// Planar 4:2:0 frame bytes in, clipped RGB pixels with coordinates out.
// ----------------------------------------------------------------------------
// Bytes arrive in file order: the luma plane, then Cb, then Cr. Luma and Cb
// bytes are written to on-chip RAMs (MAX_WIDTH*MAX_HEIGHT and a quarter of
// that, never cleared). Each Cr byte closes one 2x2 block and yields four
// pixels in the order top-left, top-right, bottom-left, bottom-right; its
// processing takes a one-bit-per-cycle restoring divider that splits the
// chroma index into block column and row, one luma RAM read per pixel, and
// any output stall. Registers: frame_width at 0x0, frame_height at 0x4.
// ----------------------------------------------------------------------------
module yuv420_planar_to_rgb_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            sample,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [9:0]            pixel_x,
	output logic [9:0]            pixel_y,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic                  last_of_block,
	output logic                  last_of_frame
);

	import y420rgb_pkg::*;

	localparam int LUMA_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int CB_DEPTH   = LUMA_DEPTH / 4;
	localparam int LAW        = (LUMA_DEPTH > 1) ? $clog2(LUMA_DEPTH) : 1;
	localparam int CAW        = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int POS_W      = $clog2(LUMA_DEPTH + LUMA_DEPTH / 2 + 1);
	localparam int DCW        = $clog2(CAW + 1);

	y420rgb_state_t state_q, state_d;

	dim_cfg_t          frame_width_q, frame_height_q;
	logic [POS_W-1:0]  bytepos_q;
	logic [7:0]        sample_q;
	logic              fs_q;
	logic [WW-1:0]     w_q;
	logic [POS_W-1:0]  luma_n_q, pos_q;
	logic [CAW-1:0]    quo_q;
	logic [WW-1:0]     rem_q;
	logic [DCW-1:0]    div_cnt_q;
	logic              lf_q;
	chan_t             r_off_q, g_off_q, b_off_q;
	logic [XW-1:0]     x0_q;
	logic [YW-1:0]     y0_q;
	logic [LAW-1:0]    base_q;
	logic [1:0]        pix_q;
	logic              out_valid_q;
	logic [XW-1:0]     pixel_x_q;
	logic [YW-1:0]     pixel_y_q;
	logic [7:0]        red_q, green_q, blue_q;
	logic              lob_q, lof_q;

	logic [31:0]          fw32, fh32;
	logic [WW-1:0]        eff_w;
	logic [HW-1:0]        eff_h;
	logic [WW+HW-1:0]     dim_prod;
	logic [POS_W-1:0]     chroma_n, total, pos_c, pos_next, cb_idx, cr_idx;
	logic                 is_luma, is_cb;
	logic [WW-1:0]        half, rem_sh;
	logic                 rem_ge;
	logic [YW-1:0]        y0_c;
	logic [YW+WW-1:0]     base_prod;
	logic [LAW:0]         pix_addr;
	chan_t                su, sv, sy;
	chan_t                r_off_c, g_off_c, b_off_c;

	logic                 luma_we, cb_we;
	logic [LAW-1:0]       luma_addr;
	logic [CAW-1:0]       cb_addr;
	logic [7:0]           luma_rdata, cb_rdata;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_RESET;
			frame_height_q <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// clamp dimensions to the supported range, force even
	always_comb begin
		fw32 = 32'(frame_width_q);
		fh32 = 32'(frame_height_q);
		if (fw32 < 32'd2) fw32 = 32'd2;
		if (fw32 > 32'(MAX_WIDTH)) fw32 = 32'(MAX_WIDTH);
		if (fh32 < 32'd2) fh32 = 32'd2;
		if (fh32 > 32'(MAX_HEIGHT)) fh32 = 32'(MAX_HEIGHT);
		eff_w = WW'(fw32 & 32'hFFFF_FFFE);
		eff_h = HW'(fh32 & 32'hFFFF_FFFE);
	end

	assign dim_prod = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);

	// plane boundaries
	assign chroma_n = luma_n_q >> 2;
	assign total    = luma_n_q + (luma_n_q >> 1);
	assign pos_c    = (fs_q || (bytepos_q >= total)) ? '0 : bytepos_q;
	assign pos_next = pos_q + POS_W'(1);
	assign cb_idx   = pos_q - luma_n_q;
	assign cr_idx   = cb_idx - chroma_n;
	assign is_luma  = pos_q < luma_n_q;
	assign is_cb    = pos_q < (luma_n_q + chroma_n);

	// restoring divider step
	assign half   = w_q >> 1;
	assign rem_sh = {rem_q[WW-2:0], quo_q[CAW-1]};
	assign rem_ge = rem_sh >= half;

	assign y0_c      = YW'({quo_q, 1'b0});
	assign base_prod = (YW+WW)'(y0_c) * (YW+WW)'(w_q);
	assign pix_addr  = (LAW+1)'(base_q) + (pix_q[1] ? (LAW+1)'(w_q) : '0)
	                 + (LAW+1)'(x0_q) + (LAW+1)'(pix_q[0]);

	// chroma offsets shared by the four pixels of a block
	always_comb begin
		su = chan_t'({3'b000, cb_rdata});
		sv = chan_t'({3'b000, sample_q});
		sy = chan_t'({3'b000, luma_rdata});
		r_off_c = sv + (sv >>> 2) + (sv >>> 3) + (sv >>> 6) - R_BIAS;
		g_off_c = G_BIAS_U + G_BIAS_V - (su >>> 2) - (su >>> 4) - (su >>> 5)
		        - (sv >>> 1) - (sv >>> 3) - (sv >>> 4) - (sv >>> 6);
		b_off_c = su + (su >>> 1) + (su >>> 2) - B_BIAS;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		luma_we   = 1'b0;
		cb_we     = 1'b0;
		luma_addr = LAW'(pix_addr);
		cb_addr   = CAW'(cr_idx);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIM;
			end
			ST_DIM: state_d = ST_POS;
			ST_POS: state_d = ST_CLASS;
			ST_CLASS: begin
				luma_addr = LAW'(pos_q);
				if (is_luma) begin
					luma_we = 1'b1;
					state_d = ST_IDLE;
				end else if (is_cb) begin
					cb_we   = 1'b1;
					cb_addr = CAW'(cb_idx);
					state_d = ST_IDLE;
				end else begin
					state_d = ST_CHROMA;
				end
			end
			ST_CHROMA: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCW'(CAW - 1)) state_d = ST_BASE;
			end
			ST_BASE: state_d = ST_ADDR;
			ST_ADDR: state_d = ST_READ;
			ST_READ: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = (pix_q == 2'd3) ? ST_IDLE : ST_ADDR;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytepos_q   <= '0;
			out_valid_q <= 1'b0;
			pix_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLASS: bytepos_q <= (pos_next >= total) ? '0 : pos_next;
				ST_CHROMA: div_cnt_q <= '0;
				ST_DIV: div_cnt_q <= div_cnt_q + DCW'(1);
				ST_BASE: pix_q <= '0;
				ST_READ: out_valid_q <= 1'b1;
				ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						pix_q       <= pix_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= sample;
				fs_q     <= frame_start;
			end
			ST_DIM: begin
				w_q      <= eff_w;
				luma_n_q <= POS_W'(dim_prod);
			end
			ST_POS: pos_q <= pos_c;
			ST_CLASS: lf_q <= (cr_idx + POS_W'(1)) == chroma_n;
			ST_CHROMA: begin
				r_off_q <= r_off_c;
				g_off_q <= g_off_c;
				b_off_q <= b_off_c;
				rem_q   <= '0;
				quo_q   <= CAW'(cr_idx);
			end
			ST_DIV: begin
				rem_q <= rem_ge ? (rem_sh - half) : rem_sh;
				quo_q <= CAW'({quo_q, rem_ge});
			end
			ST_BASE: begin
				x0_q   <= XW'({rem_q, 1'b0});
				y0_q   <= y0_c;
				base_q <= LAW'(base_prod);
			end
			ST_READ: begin
				pixel_x_q <= x0_q | XW'(pix_q[0]);
				pixel_y_q <= y0_q | YW'(pix_q[1]);
				red_q     <= clip8(sy + r_off_q);
				green_q   <= clip8(sy + g_off_q);
				blue_q    <= clip8(sy + b_off_q);
				lob_q     <= pix_q == 2'd3;
				lof_q     <= (pix_q == 2'd3) && lf_q;
			end
			default: ;
		endcase
	end

	y420rgb_ram #(
		.WIDTH (8),
		.DEPTH (LUMA_DEPTH)
	) u_luma_ram (
		.clk   (clk),
		.we    (luma_we),
		.addr  (luma_addr),
		.wdata (sample_q),
		.rdata (luma_rdata)
	);

	y420rgb_ram #(
		.WIDTH (8),
		.DEPTH (CB_DEPTH)
	) u_cb_ram (
		.clk   (clk),
		.we    (cb_we),
		.addr  (cb_addr),
		.wdata (sample_q),
		.rdata (cb_rdata)
	);

	assign in_ready      = state_q == ST_IDLE;
	assign out_valid     = out_valid_q;
	assign pixel_x       = 10'(pixel_x_q);
	assign pixel_y       = 10'(pixel_y_q);
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign last_of_block = lob_q;
	assign last_of_frame = lof_q;

endmodule

/* hdl/y420rgb_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y420rgb_chk
// Port-level checks of the 4:2:0 converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "yuv420_planar_to_rgb_top_assert.svh"

module y420rgb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] pixel_x,
	input logic [9:0] pixel_y,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last_of_block,
	input logic       last_of_frame
);

	`Y420RGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({pixel_x, pixel_y, red, green, blue, last_of_block, last_of_frame}))
	`Y420RGB_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
	`Y420RGB_ASSERT_NEXT(a_in_then_quiet, in_valid && in_ready, !out_valid)
	`Y420RGB_ASSERT_SAME(a_block_corner, out_valid && last_of_block, pixel_x[0] && pixel_y[0])
	`Y420RGB_ASSERT_SAME(a_frame_in_block, out_valid && last_of_frame, last_of_block)

endmodule

bind yuv420_planar_to_rgb_top y420rgb_chk u_y420rgb_chk (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
// Frame bytes go in over a valid/ready channel and RGB pixels come back over
// another. A scoreboard keeps its own luma and Cb planes, byte position and
// frame size, predicts the four pixels that each Cr byte yields and checks
// every pixel transfer field by field. Frame size is set through the register
// port between phases and read back. The run covers clipping extremes, frame
// restarts, wrap at end of frame, size changes mid-frame, out-of-range and odd
// sizes, the widest and tallest sizes briefly, a long output hold-off, and
// random small frames mixed with aborted frames and stray bytes.
// ----------------------------------------------------------------------------

import y420rgb_pkg::*;

typedef struct packed {
	logic [9:0] px;
	logic [9:0] py;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       lob;
	logic       lof;
} rgb_pixel_t;

class pixel_scoreboard;
	localparam int unsigned MAX_DIM = 1024;

	dim_cfg_t     width_cfg;
	dim_cfg_t     height_cfg;
	int unsigned  position;
	bit [7:0]     luma_plane [int unsigned];
	bit [7:0]     cb_plane [int unsigned];
	rgb_pixel_t   pixels_due[$];
	int           errors;

	function new();
		width_cfg = DIM_RESET;
		height_cfg = DIM_RESET;
		position = 0;
		errors = 0;
	endfunction

	function int unsigned span(dim_cfg_t v);
		int unsigned d;
		d = v;
		if (d < 2) d = 2;
		if (d > MAX_DIM) d = MAX_DIM;
		return d & ~32'd1;
	endfunction

	function int unsigned luma_bytes();
		return span(width_cfg) * span(height_cfg);
	endfunction

	function int unsigned frame_bytes();
		return luma_bytes() + luma_bytes() / 2;
	endfunction

	function void set_dim(logic idx, logic [31:0] v);
		if (idx == REG_FRAME_WIDTH) begin
			width_cfg = v[CFG_W-1:0];
		end else begin
			height_cfg = v[CFG_W-1:0];
		end
	endfunction

	function int unsigned next_slot(bit fs);
		int unsigned p;
		p = fs ? 0 : position;
		if (p >= frame_bytes()) p = 0;
		return p;
	endfunction

	function bit would_read_blank(bit fs);
		int unsigned w, p, c, x0, y0;
		w = span(width_cfg);
		p = next_slot(fs);
		if (p < luma_bytes() + luma_bytes() / 4) return 1'b0;
		c = p - luma_bytes() - luma_bytes() / 4;
		x0 = 2 * (c % (w / 2));
		y0 = 2 * (c / (w / 2));
		return !cb_plane.exists(c) || !luma_plane.exists(y0 * w + x0) ||
			!luma_plane.exists(y0 * w + x0 + 1) || !luma_plane.exists((y0 + 1) * w + x0) ||
			!luma_plane.exists((y0 + 1) * w + x0 + 1);
	endfunction

	function logic [7:0] clamp8(int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function rgb_pixel_t shade(input int unsigned x, input int unsigned y, input int unsigned w,
			input int u, input int v, input bit lb, input bit lf);
		rgb_pixel_t p;
		int yy, r, g, b;
		yy = luma_plane[y * w + x];
		r = yy + v + (v >> 2) + (v >> 3) + (v >> 6) - 179;
		g = yy - (u >> 2) - (u >> 4) - (u >> 5) + 44 - (v >> 1) - (v >> 3) - (v >> 4)
			- (v >> 6) + 91;
		b = yy + u + (u >> 1) + (u >> 2) - 227;
		p.px = x[9:0];
		p.py = y[9:0];
		p.red = clamp8(r);
		p.green = clamp8(g);
		p.blue = clamp8(b);
		p.lob = lb;
		p.lof = lf;
		return p;
	endfunction

	function void take_byte(logic [7:0] s, logic fs);
		int unsigned w, ln, cn, p, c, x0, y0;
		int u, v;
		w = span(width_cfg);
		ln = luma_bytes();
		cn = ln / 4;
		p = next_slot(fs);
		if (p < ln) begin
			luma_plane[p] = s;
		end else if (p < ln + cn) begin
			cb_plane[p - ln] = s;
		end else begin
			c = p - ln - cn;
			x0 = 2 * (c % (w / 2));
			y0 = 2 * (c / (w / 2));
			u = cb_plane[c];
			v = s;
			pixels_due.push_back(shade(x0, y0, w, u, v, 1'b0, 1'b0));
			pixels_due.push_back(shade(x0 + 1, y0, w, u, v, 1'b0, 1'b0));
			pixels_due.push_back(shade(x0, y0 + 1, w, u, v, 1'b0, 1'b0));
			pixels_due.push_back(shade(x0 + 1, y0 + 1, w, u, v, 1'b1, c + 1 == cn));
		end
		position = p + 1;
		if (position >= ln + 2 * cn) position = 0;
	endfunction

	function void tally(string field, logic [9:0] want, logic [9:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_pixel(rgb_pixel_t got);
		rgb_pixel_t want;
		if (pixels_due.size() == 0) begin
			$error("pixel (%0d,%0d) transferred with none pending", got.px, got.py);
			errors++;
		end else begin
			want = pixels_due.pop_front();
			tally("pixel_x", want.px, got.px);
			tally("pixel_y", want.py, got.py);
			tally("red", want.red, got.red);
			tally("green", want.green, got.green);
			tally("blue", want.blue, got.blue);
			tally("last_of_block", want.lob, got.lob);
			tally("last_of_frame", want.lof, got.lof);
		end
	endfunction
endclass

module tb_top;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  sample;
	logic        frame_start;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_of_block;
	logic        last_of_frame;

	bit tx_steady;
	bit rx_steady;
	bit hold_req;
	int sent;

	pixel_scoreboard sb = new();

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	yuv420_planar_to_rgb_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.last_of_block (last_of_block),
		.last_of_frame (last_of_frame)
	);

	function int idle_span();
		return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		return (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
	endfunction

	task write_dim(input logic idx, input int unsigned val);
		logic [31:0] word;
		word = ($urandom() & 32'hFFFF_F800) | (val & 32'h0000_07FF);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_dim(idx, word);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== word[CFG_W-1:0]) begin
			$error("prdata: expected %0d, got %0d", word[CFG_W-1:0], prdata[CFG_W-1:0]);
			sb.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task push_byte(input logic [7:0] s, input logic fs);
		int gap;
		logic f;
		f = fs;
		// restart the frame rather than touch planes never written
		if (sb.would_read_blank(f)) f = 1'b1;
		if (!tx_steady && $urandom_range(0, 2) == 0) begin
			gap = idle_span();
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		frame_start <= f;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(s, f);
		sent++;
		@(negedge clk);
	endtask

	task send_frame(input bit squeeze);
		int unsigned ln, total;
		logic fs;
		ln = sb.luma_bytes();
		total = sb.frame_bytes();
		fs = (sb.position == 0 && $urandom_range(0, 1) == 0) ? 1'b0 : 1'b1;
		for (int unsigned i = 0; i < total; i++) begin
			if (squeeze && i == ln + ln / 4) hold_req = 1'b1;
			push_byte(rand_byte(), (i == 0) ? fs : 1'b0);
		end
	endtask

	task wait_idle(input int tail);
		in_valid <= 1'b0;
		while (sb.pixels_due.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	initial begin
		int rx_wait;
		rx_wait = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_wait = 300;
			end
			if (rx_wait > 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else if (rx_steady || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				rx_wait = idle_span() - 1;
			end
		end
	end

	initial begin
		rgb_pixel_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = {pixel_x, pixel_y, red, green, blue, last_of_block, last_of_frame};
				sb.check_pixel(got);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("** yuv420_planar_to_rgb_top: FAILED **");
		$finish;
	end

	initial begin
		int pick;
		int unsigned n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample = '0;
		frame_start = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 2x2 frames: clipping extremes, wrap without frame_start, restart mid-frame
		write_dim(REG_FRAME_WIDTH, 2);
		write_dim(REG_FRAME_HEIGHT, 2);
		push_byte(8'd0, 1'b1);
		push_byte(8'd255, 1'b0);
		push_byte(8'd128, 1'b0);
		push_byte(8'd1, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b1);
		push_byte(8'd0, 1'b0);
		push_byte(8'd77, 1'b0);
		push_byte(8'd200, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);

		// odd and zero sizes, then shrink the frame past the current position
		wait_idle(60);
		write_dim(REG_FRAME_WIDTH, 5);
		write_dim(REG_FRAME_HEIGHT, 0);
		for (int i = 0; i < 7; i++) push_byte(rand_byte(), i == 0);
		wait_idle(60);
		write_dim(REG_FRAME_WIDTH, 2);
		write_dim(REG_FRAME_HEIGHT, 3);
		for (int i = 0; i < 6; i++) push_byte(rand_byte(), 1'b0);

		// widest and tallest sizes briefly
		wait_idle(60);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		write_dim(REG_FRAME_WIDTH, 2047);
		write_dim(REG_FRAME_HEIGHT, 1);
		for (int i = 0; i < 16; i++) push_byte(rand_byte(), i == 0);
		wait_idle(60);
		write_dim(REG_FRAME_WIDTH, 0);
		write_dim(REG_FRAME_HEIGHT, 1024);
		for (int i = 0; i < 16; i++) push_byte(rand_byte(), i == 0);

		// hold the output through the Cr plane so the input backs up
		wait_idle(60);
		rx_steady = 1'b0;
		write_dim(REG_FRAME_WIDTH, 8);
		write_dim(REG_FRAME_HEIGHT, 4);
		send_frame(1'b1);

		while (sent < 310) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if ($urandom_range(0, 2) == 0) begin
					wait_idle(60);
					write_dim(REG_FRAME_WIDTH, $urandom_range(0, 9));
					write_dim(REG_FRAME_HEIGHT, $urandom_range(0, 7));
				end
				send_frame(1'b0);
			end else if (pick < 9) begin
				n = $urandom_range(1, sb.frame_bytes() - 1);
				for (int unsigned i = 0; i < n; i++) push_byte(rand_byte(), i == 0);
			end else begin
				n = $urandom_range(1, 6);
				for (int unsigned i = 0; i < n; i++) begin
					push_byte(rand_byte(), $urandom_range(0, 7) == 0);
				end
			end
		end

		wait_idle(100);
		if (sb.errors == 0) begin
			$display("** yuv420_planar_to_rgb_top: PASSED **");
		end else begin
			$display("** yuv420_planar_to_rgb_top: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/y420rgb_pkg.sv
hdl/y420rgb_ram.sv
hdl/yuv420_planar_to_rgb_top.sv
hdl/y420rgb_chk.sv
dv/tb_top.sv
